// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define PCCG_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pccg assertion failed");

// when ante holds, cons must hold at the same edge
`define PCCG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pccg assertion failed");

// when ante holds, cons must hold at the next edge
`define PCCG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pccg assertion failed");

`endif

// ===== rtl/pccg_pkg.sv =====
// Shared widths, constants and sequencer states of the clause generator.
package pccg_pkg;

  localparam int EVENT_W  = 10;
  localparam int LIMIT_W  = 13;
  localparam int SLOT_W   = 6;
  localparam int VAR_W    = 20;
  localparam int PERIOD_W = 7;
  // magnitude of (-slot_a - lower_limit) fits in 13 bits
  localparam int MAG_W    = 13;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd60;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQA,
    ST_SQB,
    ST_SQE,
    ST_MOD,
    ST_SCAN,
    ST_FLUSH
  } pccg_state_t;

endpackage

// ===== rtl/pccg_rem.sv =====
// Iterative shift-subtract remainder unit: mag mod dvsr, one bit per cycle.
module pccg_rem import pccg_pkg::*; #(
  parameter int TPW = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] mag,
  input  logic [TPW-1:0]   dvsr,
  output logic             done,
  output logic [TPW-1:0]   rem
);

  localparam int DW  = TPW + MAG_W - 1;
  localparam int CNW = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] acc_r, acc_nxt;
  logic [DW-1:0]    dv_r, dv_nxt;
  logic [CNW-1:0]   cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic             fits;

  // shared compare/subtract against the shifted divisor
  assign fits = DW'(acc_r) >= dv_r;

  always_comb begin
    acc_nxt  = acc_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = mag;
      dv_nxt  = DW'(dvsr) << (MAG_W - 1);
      cnt_nxt = CNW'(MAG_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (fits) begin
        acc_nxt = acc_r - MAG_W'(dv_r);
      end
      dv_nxt  = dv_r >> 1;
      cnt_nxt = cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    dv_r  <= dv_nxt;
  end

  assign done = done_r;
  assign rem  = TPW'(acc_r);

endmodule

// ===== rtl/periodic_constraint_clause_generator_unit.sv =====
// Top level of the periodic constraint clause generator.
// Usage:
//   in_*  : one transaction per row: event_a, event_b, lower_limit, upper_limit and
//           slot_a (i). For each slot j below the period the row checks whether
//           j - i falls in [lower + k*T, upper + k*T] for some k; each slot that
//           does not yields one clause transaction on out_*, in increasing j.
//   out_* : tdata = var_first, var_second, slot_b; tuser = present; tlast marks
//           the final transaction of the row. A row with no forbidden slot, or
//           with slot_a at or above the period, gives one transaction with
//           present 0, tlast 1 and zero data.
//   cfg_* : period write, taken at any edge with cfg_wr_en high; saturates to
//           MAX_PERIOD. Write only while no row is in flight.
// Row flow: a row holds the block from the accept cycle through ST_SQA, ST_SQB and
//   ST_SQE (two squarings on the shared multiplier, remainder start), ST_MOD waiting
//   on the shift-subtract remainder unit, ST_SCAN stepping through the slots j and
//   ST_FLUSH, in_tready low throughout. The tlast transaction is registered from
//   ST_FLUSH; an empty row goes from accept straight to ST_FLUSH. A stalled
//   out_tready holds the slot scan when a second clause is pending behind the output
//   register.
// Reset: period returns to 60, sequencer to idle, output register empties.
module periodic_constraint_clause_generator_unit import pccg_pkg::*; #(
  parameter int MAX_PERIOD = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // [9:0] event_a, [19:10] event_b, [32:20] lower_limit, [45:33] upper_limit,
  // [51:46] slot_a, [55:52] zero
  input  logic [55:0]         in_tdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [19:0] var_first, [39:20] var_second, [45:40] slot_b, [47:46] zero
  output logic [47:0]         out_tdata,
  // [0] present
  output logic                out_tuser,
  output logic                out_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_wr_en,
  input  logic [PERIOD_W-1:0] cfg_wr_data
);

  `include "assert_macros.svh"

  // effective period width and slot counter width
  localparam int TPW = $clog2(MAX_PERIOD + 1);
  localparam int JW  = (MAX_PERIOD > 2) ? $clog2(MAX_PERIOD) : 1;
  localparam int SQW = 2 * JW;
  localparam int PW  = 2 * EVENT_W;
  localparam int DFW = LIMIT_W + 2;

  // input unpack
  logic [EVENT_W-1:0] in_ea, in_eb;
  logic [LIMIT_W-1:0] in_lo, in_hi;
  logic [SLOT_W-1:0]  in_si;
  assign in_ea = in_tdata[9:0];
  assign in_eb = in_tdata[19:10];
  assign in_lo = in_tdata[32:20];
  assign in_hi = in_tdata[45:33];
  assign in_si = in_tdata[51:46];

  pccg_state_t state_r, state_nxt;

  logic [PERIOD_W-1:0] period_r;
  logic [TPW-1:0]      tp_cur;
  logic                row_empty;
  logic                accept;

  // row registers
  logic [EVENT_W-1:0] ea_r, eb_r;
  logic [SLOT_W-1:0]  si_r;
  logic [TPW-1:0]     tp_r;
  logic               neg_r, inv_r;
  logic [MAG_W-1:0]   mag_r;
  logic [LIMIT_W-1:0] span_r;
  logic [PW-1:0]      prod_r, ebsq_r;
  logic [VAR_W-1:0]   vf_r;
  logic [TPW-1:0]     r_r;
  logic [JW-1:0]      j_r;
  logic [SQW-1:0]     jsq_r;

  // pending clause held back until we know whether it is the last
  logic               h_valid_r;
  logic [VAR_W-1:0]   h_var2_r;
  logic [SLOT_W-1:0]  h_slot_r;

  // output register
  logic               out_valid_r;
  logic [VAR_W-1:0]   out_var1_r, out_var2_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_present_r, out_last_r;

  // datapath helpers
  logic signed [DFW-1:0] d_cur, hl_diff;
  logic [DFW-1:0]        d_abs;
  logic [EVENT_W-1:0]    mul_a;
  logic [PW-1:0]         mul_p;
  logic                  ea_lt;
  logic [VAR_W:0]        vf_sum;
  logic                  eb_lt_j;
  logic [VAR_W:0]        var2_sum;
  logic [VAR_W-1:0]      var2;
  logic                  forb, last_j, out_busy;
  logic [TPW-1:0]        r_inc, r_step;
  logic                  rem_start, rem_done;
  logic [TPW-1:0]        rem_val, r_init;

  // output strobes from the sequencer
  logic               push;
  logic [VAR_W-1:0]   push_var1, push_var2;
  logic [SLOT_W-1:0]  push_slot;
  logic               push_present, push_last;
  logic               scan_adv, hold_load;

  // period saturation and empty row detection
  always_comb begin
    if (32'(period_r) > MAX_PERIOD) begin
      tp_cur = TPW'(MAX_PERIOD);
    end else begin
      tp_cur = TPW'(period_r);
    end
  end
  assign row_empty = (tp_cur == '0) || (9'(in_si) >= 9'(tp_cur));
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // d = -i - lower, r0 = d mod T
  assign d_cur   = -$signed(DFW'(in_si)) - DFW'(signed'(in_lo));
  assign d_abs   = d_cur[DFW-1] ? DFW'(-d_cur) : DFW'(d_cur);
  assign hl_diff = DFW'(signed'(in_hi)) - DFW'(signed'(in_lo));

  // shared squarer: max(ea,i)^2 first, then eb^2
  assign ea_lt = ea_r < EVENT_W'(si_r);
  assign mul_a = (state_r == ST_SQA) ? (ea_lt ? EVENT_W'(si_r) : ea_r) : eb_r;
  assign mul_p = PW'(mul_a) * PW'(mul_a);
  assign vf_sum = ea_lt ? ((VAR_W+1)'(prod_r) + (VAR_W+1)'(ea_r) + (VAR_W+1)'(1))
                        : ((VAR_W+1)'(prod_r) + (VAR_W+1)'(ea_r) + (VAR_W+1)'(si_r)
                           + (VAR_W+1)'(1));

  assign rem_start = (state_r == ST_SQB);

  pccg_rem #(
    .TPW (TPW)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .mag   (mag_r),
    .dvsr  (tp_r),
    .done  (rem_done),
    .rem   (rem_val)
  );

  assign r_init = (neg_r && (rem_val != '0)) ? (tp_r - rem_val) : rem_val;

  // scan step: pair(eb, j) from the running square of j
  assign eb_lt_j  = 16'(eb_r) < 16'(j_r);
  assign var2_sum = eb_lt_j ? ((VAR_W+1)'(jsq_r) + (VAR_W+1)'(eb_r) + (VAR_W+1)'(1))
                            : ((VAR_W+1)'(ebsq_r) + (VAR_W+1)'(eb_r) + (VAR_W+1)'(j_r)
                               + (VAR_W+1)'(1));
  assign var2     = var2_sum[VAR_W-1:0];
  assign forb     = inv_r || (LIMIT_W'(r_r) > span_r);
  assign last_j   = (TPW'(j_r) + TPW'(1)) == tp_r;
  assign r_inc    = r_r + TPW'(1);
  assign r_step   = (r_inc == tp_r) ? '0 : r_inc;
  assign out_busy = out_valid_r && !out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = row_empty ? ST_FLUSH : ST_SQA;
        end
      end
      ST_SQA: state_nxt = ST_SQB;
      ST_SQB: state_nxt = ST_SQE;
      ST_SQE: state_nxt = ST_MOD;
      ST_MOD: begin
        if (rem_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_adv && last_j) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    push         = 1'b0;
    push_var1    = vf_r;
    push_var2    = h_var2_r;
    push_slot    = h_slot_r;
    push_present = 1'b1;
    push_last    = 1'b0;
    scan_adv     = 1'b0;
    hold_load    = 1'b0;
    case (state_r)
      ST_SCAN: begin
        if (!(forb && h_valid_r && out_busy)) begin
          scan_adv  = 1'b1;
          hold_load = forb;
          push      = forb && h_valid_r;
        end
      end
      ST_FLUSH: begin
        if (!out_busy) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (!h_valid_r) begin
            push_var1    = '0;
            push_var2    = '0;
            push_slot    = '0;
            push_present = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      period_r    <= PERIOD_RESET;
      out_valid_r <= 1'b0;
      h_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        h_valid_r <= 1'b0;
      end else if (hold_load) begin
        h_valid_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ea_r   <= in_ea;
      eb_r   <= in_eb;
      si_r   <= in_si;
      tp_r   <= tp_cur;
      neg_r  <= d_cur[DFW-1];
      mag_r  <= MAG_W'(d_abs);
      inv_r  <= hl_diff[DFW-1];
      span_r <= LIMIT_W'(hl_diff);
    end
    if (state_r == ST_SQA || state_r == ST_SQB) begin
      prod_r <= mul_p;
    end
    if (state_r == ST_SQB) begin
      vf_r <= vf_sum[VAR_W-1:0];
    end
    if (state_r == ST_SQE) begin
      ebsq_r <= prod_r;
    end
    if (state_r == ST_MOD && rem_done) begin
      r_r   <= r_init;
      j_r   <= '0;
      jsq_r <= '0;
    end else if (scan_adv) begin
      r_r   <= r_step;
      j_r   <= j_r + JW'(1);
      jsq_r <= jsq_r + SQW'({j_r, 1'b1});
    end
    if (hold_load) begin
      h_var2_r <= var2;
      h_slot_r <= SLOT_W'(j_r);
    end
    if (push) begin
      out_var1_r    <= push_var1;
      out_var2_r    <= push_var2;
      out_slot_r    <= push_slot;
      out_present_r <= push_present;
      out_last_r    <= push_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_slot_r, out_var2_r, out_var1_r};
  assign out_tuser  = out_present_r;
  assign out_tlast  = out_last_r;

  // an empty-row marker always closes its row
  `PCCG_ASSERT_IMPL(a_empty_is_last, out_tvalid && !out_tuser, out_tlast)
  // remainder unit only reports while the sequencer waits for it
  `PCCG_ASSERT_IMPL(a_rem_done_in_mod, rem_done, state_r == ST_MOD)
  // running residue stays reduced during the scan
  `PCCG_ASSERT_IMPL(a_residue_range, state_r == ST_SCAN, r_r < tp_r)
  // no second row is taken right after one is accepted
  `PCCG_ASSERT_NEXT(a_busy_after_accept, accept, !in_tready)

endmodule
